// ===== sv/seven_segment_raster_scan_unit_defines.svh =====
// ---------------------------------------------------------------------------
// seven segment raster scan unit assertion macros
// shared property wrappers for the rtl checks
// ---------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_RASTER_SCAN_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_RASTER_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssrs check failed");

// next-cycle implication, checked outside reset
`define SSRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssrs check failed");

`endif

// ===== sv/ssrs_pkg.sv =====
// ---------------------------------------------------------------------------
// ssrs_pkg
// widths, codes, segment table and control structs of the raster scan unit
// ---------------------------------------------------------------------------
package ssrs_pkg;

  localparam int MAX_DIGITS  = 16;
  localparam int MAX_SEGMENT = 15;
  localparam int DIGIT_W     = 4;
  localparam int SEG_W       = 4;
  localparam int POS_W       = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ROW_W       = $clog2(2 * MAX_SEGMENT + 3);
  localparam int COL_W       = $clog2(MAX_SEGMENT + 3);

  typedef enum logic [1:0] {
    GLYPH_SPACE = 2'd0,
    GLYPH_BAR   = 2'd1,
    GLYPH_DASH  = 2'd2
  } glyph_t;

  typedef enum logic [2:0] {
    SEG_TOP         = 3'd0,
    SEG_UPPER_LEFT  = 3'd1,
    SEG_UPPER_RIGHT = 3'd2,
    SEG_MIDDLE      = 3'd3,
    SEG_LOWER_LEFT  = 3'd4,
    SEG_LOWER_RIGHT = 3'd5,
    SEG_BOTTOM      = 3'd6
  } segment_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_ready;
    logic out_free;
  } ctrl_stat_t;

  // bit n is segment n
  function automatic logic [6:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [6:0] p;
    unique case (digit)
      4'd0:    p = 7'b1110111;
      4'd1:    p = 7'b0100100;
      4'd2:    p = 7'b1011101;
      4'd3:    p = 7'b1101101;
      4'd4:    p = 7'b0101110;
      4'd5:    p = 7'b1101011;
      4'd6:    p = 7'b1111011;
      4'd7:    p = 7'b0100101;
      4'd8:    p = 7'b1111111;
      4'd9:    p = 7'b1101111;
      default: p = 7'b0000000;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/ssrs_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssrs_ctrl
// request sequencer: takes words, issues load, fetch and emit commands
// ---------------------------------------------------------------------------
`include "seven_segment_raster_scan_unit_defines.svh"

module ssrs_ctrl
  import ssrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       req_type,
  output logic       in_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && req_type && stat.scan_ready) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cmd.load  = 1'b0;
    cmd.fetch = 1'b0;
    cmd.emit  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid && !req_type;
        // advance before a complete number is dropped
        cmd.fetch = in_valid && req_type && stat.scan_ready;
      end
      S_FETCH: begin
        cmd.emit = stat.out_free;
      end
      default: ;
    endcase
  end

  `SSRS_ASSERT_NEXT(a_fetch_enters, cmd.fetch, state == S_FETCH)
  `SSRS_ASSERT_NEXT(a_fetch_waits, state == S_FETCH && !stat.out_free, state == S_FETCH)

endmodule

// ===== sv/ssrs_datapath.sv =====
// ---------------------------------------------------------------------------
// ssrs_datapath
// digit store, scan counters, glyph decode and output register
// ---------------------------------------------------------------------------
`include "seven_segment_raster_scan_unit_defines.svh"

module ssrs_datapath
  import ssrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SEG_W-1:0]   cfg_wr_data,
  input  logic [DIGIT_W-1:0] digit_value,
  input  logic               last_digit,
  input  ctrl_cmd_t          cmd,
  output ctrl_stat_t         stat,
  input  logic               out_stall,
  output logic               out_valid,
  output glyph_t             glyph,
  output logic               end_of_row,
  output logic               end_of_frame
);

  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_digit;

  logic [SEG_W-1:0]   seg_len;
  logic [COUNT_W-1:0] digit_count;
  logic [COUNT_W-1:0] digit_count_next;
  logic               loading_done;
  logic               loading_done_next;
  logic [ROW_W-1:0]   row_index;
  logic [ROW_W-1:0]   row_index_next;
  logic [COL_W-1:0]   cell_column;
  logic [COL_W-1:0]   cell_column_next;
  logic [POS_W-1:0]   digit_position;
  logic [POS_W-1:0]   digit_position_next;

  logic [COUNT_W-1:0] load_base;
  logic               store_wr;

  logic [ROW_W-1:0]   mid_row;
  logic [ROW_W-1:0]   last_row;
  logic [COL_W-1:0]   bar_col;
  logic [COL_W-1:0]   end_col;
  logic [COUNT_W-1:0] pos_plus;
  logic               dash_row;
  logic               upper;
  logic [6:0]         segs;
  glyph_t             glyph_calc;
  logic               eor_calc;
  logic               eof_calc;

  // a load after a finished number starts over
  assign load_base = loading_done ? '0 : digit_count;
  assign store_wr  = cmd.load && (load_base < COUNT_W'(MAX_DIGITS));

  always_ff @(posedge clk) begin
    if (store_wr) begin
      digit_store[load_base[POS_W-1:0]] <= digit_value;
    end
    if (cmd.fetch) begin
      rd_digit <= digit_store[digit_position];
    end
  end

  assign mid_row  = ROW_W'(seg_len) + ROW_W'(1);
  assign last_row = ROW_W'({seg_len, 1'b0}) + ROW_W'(2);
  assign bar_col  = COL_W'(seg_len) + COL_W'(1);
  assign end_col  = COL_W'(seg_len) + COL_W'(2);
  assign pos_plus = COUNT_W'(digit_position) + COUNT_W'(1);

  assign dash_row = (row_index == '0) || (row_index == mid_row) || (row_index == last_row);
  assign upper    = row_index < mid_row;
  assign segs     = seg_pattern(rd_digit);

  always_comb begin
    glyph_calc = GLYPH_SPACE;
    priority if (cell_column == '0 && !dash_row) begin
      if (segs[upper ? SEG_UPPER_LEFT : SEG_LOWER_LEFT]) glyph_calc = GLYPH_BAR;
    end else if (cell_column == bar_col && !dash_row) begin
      if (segs[upper ? SEG_UPPER_RIGHT : SEG_LOWER_RIGHT]) glyph_calc = GLYPH_BAR;
    end else if (cell_column != '0 && cell_column <= COL_W'(seg_len) && dash_row) begin
      priority if (row_index == '0) begin
        if (segs[SEG_TOP]) glyph_calc = GLYPH_DASH;
      end else if (row_index == last_row) begin
        if (segs[SEG_BOTTOM]) glyph_calc = GLYPH_DASH;
      end else begin
        if (segs[SEG_MIDDLE]) glyph_calc = GLYPH_DASH;
      end
    end else begin
      glyph_calc = GLYPH_SPACE;
    end
  end

  assign eor_calc = (cell_column == end_col) && (pos_plus == digit_count);
  assign eof_calc = eor_calc && (row_index == last_row);

  always_comb begin
    digit_count_next    = digit_count;
    loading_done_next   = loading_done;
    row_index_next      = row_index;
    cell_column_next    = cell_column;
    digit_position_next = digit_position;
    priority if (cfg_wr_en) begin
      row_index_next      = '0;
      cell_column_next    = '0;
      digit_position_next = '0;
    end else if (cmd.load) begin
      digit_count_next  = store_wr ? load_base + COUNT_W'(1) : load_base;
      loading_done_next = last_digit;
      if (loading_done || last_digit) begin
        row_index_next      = '0;
        cell_column_next    = '0;
        digit_position_next = '0;
      end
    end else if (cmd.emit) begin
      if (cell_column < end_col) begin
        cell_column_next = cell_column + COL_W'(1);
      end else begin
        cell_column_next = '0;
        if (pos_plus < digit_count) begin
          digit_position_next = digit_position + POS_W'(1);
        end else begin
          digit_position_next = '0;
          row_index_next = (row_index < last_row) ? row_index + ROW_W'(1) : '0;
        end
      end
    end else begin
      // nothing moves, counters hold
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len        <= SEG_W'(1);
      digit_count    <= '0;
      loading_done   <= 1'b0;
      row_index      <= '0;
      cell_column    <= '0;
      digit_position <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seg_len <= cfg_wr_data;
      end
      digit_count    <= digit_count_next;
      loading_done   <= loading_done_next;
      row_index      <= row_index_next;
      cell_column    <= cell_column_next;
      digit_position <= digit_position_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      glyph        <= glyph_calc;
      end_of_row   <= eor_calc;
      end_of_frame <= eof_calc;
    end
  end

  assign stat.scan_ready = loading_done && (digit_count != '0);
  assign stat.out_free   = !out_valid || !out_stall;

  `SSRS_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid)
  `SSRS_ASSERT_NOW(a_frame_in_row, out_valid && end_of_frame, end_of_row)
  `SSRS_ASSERT_NEXT(a_stalled_word_kept, out_valid && out_stall && !cmd.emit,
                    out_valid && $stable(glyph))

endmodule

// ===== sv/seven_segment_raster_scan_unit.sv =====
// ---------------------------------------------------------------------------
// seven_segment_raster_scan_unit
// scaled seven-segment figure generator, one glyph word per advance request
// ---------------------------------------------------------------------------
// A load word (req_type 0) stores one digit; the digit with last_digit set
// closes the number, and a later load starts a new one. An advance word
// (req_type 1) reads the digit store into a register when it is accepted,
// then the glyph, end_of_row and end_of_frame go into the output register
// once the output is free; no new word is accepted until then. The output
// register lets the next word be accepted while a result waits under
// out_stall. Advances before a number is complete give no result. A write
// of segment_length returns the scan to the first character of the figure.

module seven_segment_raster_scan_unit
  import ssrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SEG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [DIGIT_W-1:0] digit_value,
  input  logic               last_digit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         glyph,
  output logic               end_of_row,
  output logic               end_of_frame
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  glyph_t     glyph_code;

  ssrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ssrs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .digit_value  (digit_value),
    .last_digit   (last_digit),
    .cmd          (cmd),
    .stat         (stat),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .glyph        (glyph_code),
    .end_of_row   (end_of_row),
    .end_of_frame (end_of_frame)
  );

  assign glyph = glyph_code;

endmodule
